// ----- design/platform_interrupt_controller_defines.svh -----
// assertion macros for the platform interrupt controller
`ifndef PLATFORM_INTERRUPT_CONTROLLER_DEFINES_SVH
`define PLATFORM_INTERRUPT_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PIC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pic: assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PIC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pic: assertion failed");

`endif

// ----- design/pic_pkg.sv -----
// shared constants and types for the platform interrupt controller
`timescale 1ns / 1ps

package pic_pkg;

  // sizing
  localparam int NUM_SOURCES   = 32;
  localparam int NUM_CONTEXTS  = 2;
  localparam int PRIORITY_BITS = 3;
  localparam int PRIO_W        = PRIORITY_BITS;

  // sources are stored padded to whole 32-bit words
  localparam int EN_WORDS   = (NUM_SOURCES + 31) / 32;
  localparam int EN_BITS    = EN_WORDS * 32;

  // the compare unit looks at one group of sources per cycle while the sequencer scans
  localparam int GROUP      = 8;
  localparam int NUM_GROUPS = EN_BITS / GROUP;
  localparam int GRP_W      = $clog2(GROUP);
  localparam int GI_W       = $clog2(NUM_GROUPS);
  localparam int ID_W       = GI_W + GRP_W;

  localparam int CTX_W      = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  // contexts reported on the notify port
  localparam int NOTE_CTX   = (NUM_CONTEXTS < 2) ? NUM_CONTEXTS : 2;

  // item modes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_REQ   = 2'd2;

  // register map bases
  localparam logic [25:0] PEND_BASE = 26'h000_1000;
  localparam logic [25:0] EN_BASE   = 26'h000_2000;
  localparam logic [25:0] CTX_BASE  = 26'h020_0000;

  // word index within a context page
  localparam logic [9:0] CTX_REG_THRESH = 10'd0;
  localparam logic [9:0] CTX_REG_CLAIM  = 10'd1;

  // one group of sources as seen by the compare unit
  typedef struct packed {
    logic [GROUP-1:0][PRIO_W-1:0] prio;
    logic [GROUP-1:0]             qual;
    logic [PRIO_W-1:0]            thresh;
  } pic_row_t;

  // claim side effect on the source state
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } pic_claim_t;

  // bus decode seen by the sequencer
  typedef struct packed {
    logic             claim_rd;
    logic [CTX_W-1:0] ctx;
  } pic_dec_t;

endpackage

// ----- design/pic_regs.sv -----
// register file and bus decode of the platform interrupt controller
`timescale 1ns / 1ps

module pic_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            mode,
  input  logic [25:0]           offset,
  input  logic [31:0]           wdata,
  input  logic [4:0]            source_id,
  input  logic                  access_en,
  input  logic                  scan_en,
  input  logic [pic_pkg::GI_W-1:0]  scan_grp,
  input  logic [pic_pkg::CTX_W-1:0] scan_ctx,
  input  pic_pkg::pic_claim_t   claim,
  output logic [31:0]           rd_data,
  output pic_pkg::pic_dec_t     dec,
  output pic_pkg::pic_row_t     row
);

  // source and context state
  logic [pic_pkg::PRIO_W-1:0]  prio_r   [pic_pkg::EN_BITS];
  logic [pic_pkg::EN_BITS-1:0] pend_r;
  logic [pic_pkg::EN_BITS-1:0] insvc_r;
  logic [pic_pkg::EN_BITS-1:0] enable_r [pic_pkg::NUM_CONTEXTS];
  logic [pic_pkg::PRIO_W-1:0]  thresh_r [pic_pkg::NUM_CONTEXTS];

  logic [25:0]                  off_w;
  logic                         is_prio, is_pend, is_en, is_ctxp;
  logic [9:0]                   prio_id;
  logic                         prio_ok;
  logic [pic_pkg::ID_W-1:0]     prio_idx;
  logic [9:0]                   pend_w;
  logic                         pend_ok;
  logic [20:0]                  en_rel;
  logic [13:0]                  en_ctx;
  logic [4:0]                   en_w;
  logic                         en_ok;
  logic [25:0]                  cp_rel;
  logic [13:0]                  cp_ctx;
  logic [9:0]                   cp_reg;
  logic                         cp_ok;
  logic                         thr_hit, claim_hit;
  logic [pic_pkg::CTX_W-1:0]    bus_ctx, ctx_sel;
  logic [pic_pkg::GI_W-1:0]     row_sel;
  logic [pic_pkg::EN_BITS-1:0]  en_vec;
  logic [31:0]                  pend_word, en_word, en_mask;
  logic [pic_pkg::ID_W-1:0]     src_idx, done_idx;
  logic                         req_ok, done_ok;

  // address decode, low two offset bits dropped
  always_comb begin
    off_w    = {offset[25:2], 2'b00};
    is_prio  = off_w < pic_pkg::PEND_BASE;
    is_pend  = !is_prio && (off_w < pic_pkg::EN_BASE);
    is_en    = (off_w >= pic_pkg::EN_BASE) && (off_w < pic_pkg::CTX_BASE);
    is_ctxp  = off_w >= pic_pkg::CTX_BASE;

    prio_id  = off_w[11:2];
    prio_ok  = (prio_id != 10'd0) && ({1'b0, prio_id} < 11'(pic_pkg::NUM_SOURCES));
    prio_idx = prio_id[pic_pkg::ID_W-1:0];

    pend_w   = off_w[11:2];
    pend_ok  = pend_w < 10'(pic_pkg::EN_WORDS);

    // enable block: 0x80 bytes per context
    en_rel   = 21'(off_w - pic_pkg::EN_BASE);
    en_ctx   = en_rel[20:7];
    en_w     = en_rel[6:2];
    en_ok    = (en_ctx < 14'(pic_pkg::NUM_CONTEXTS)) &&
               ({1'b0, en_w} < 6'(pic_pkg::EN_WORDS));

    // context pages: 0x1000 bytes per context
    cp_rel   = off_w - pic_pkg::CTX_BASE;
    cp_ctx   = cp_rel[25:12];
    cp_reg   = cp_rel[11:2];
    cp_ok    = cp_ctx < 14'(pic_pkg::NUM_CONTEXTS);
    thr_hit  = is_ctxp && cp_ok && (cp_reg == pic_pkg::CTX_REG_THRESH);
    claim_hit = is_ctxp && cp_ok && (cp_reg == pic_pkg::CTX_REG_CLAIM);

    bus_ctx  = is_en ? en_ctx[pic_pkg::CTX_W-1:0] : cp_ctx[pic_pkg::CTX_W-1:0];
  end

  // one row and one context are read per cycle, shared by bus and scan
  always_comb begin
    row_sel = scan_en ? scan_grp : prio_idx[pic_pkg::ID_W-1:pic_pkg::GRP_W];
    ctx_sel = scan_en ? scan_ctx : bus_ctx;
    en_vec  = enable_r[ctx_sel];
    for (int k = 0; k < pic_pkg::GROUP; k++) begin
      row.prio[k] = prio_r[{row_sel, pic_pkg::GRP_W'(k)}];
      row.qual[k] = pend_r[{row_sel, pic_pkg::GRP_W'(k)}] &
                    en_vec[{row_sel, pic_pkg::GRP_W'(k)}];
    end
    row.thresh = thresh_r[ctx_sel];
  end

  // word views of the bit vectors
  always_comb begin
    pend_word = '0;
    en_word   = '0;
    for (int w = 0; w < pic_pkg::EN_WORDS; w++) begin
      if (pend_w == 10'(w)) begin
        pend_word = pend_r[w*32 +: 32];
      end
      if ({1'b0, en_w} == 6'(w)) begin
        en_word = en_vec[w*32 +: 32];
      end
    end
    // enable bits that belong to real sources
    for (int b = 0; b < 32; b++) begin
      en_mask[b] = ((int'(en_w) * 32 + b) >= 1) &&
                   ((int'(en_w) * 32 + b) < pic_pkg::NUM_SOURCES);
    end
  end

  // bus read data and claim decode
  always_comb begin
    rd_data = '0;
    if (mode == pic_pkg::MODE_READ) begin
      if (is_prio && prio_ok) begin
        rd_data = 32'(row.prio[prio_idx[pic_pkg::GRP_W-1:0]]);
      end else if (is_pend && pend_ok) begin
        rd_data = pend_word;
      end else if (is_en && en_ok) begin
        rd_data = en_word;
      end else if (thr_hit) begin
        rd_data = 32'(row.thresh);
      end
    end
    dec.claim_rd = (mode == pic_pkg::MODE_READ) && claim_hit;
    dec.ctx      = bus_ctx;
  end

  // request and completion qualifiers
  always_comb begin
    src_idx  = pic_pkg::ID_W'(source_id);
    req_ok   = (source_id != 5'd0) && (32'(source_id) < 32'(pic_pkg::NUM_SOURCES)) &&
               !pend_r[src_idx] && !insvc_r[src_idx];
    done_idx = wdata[pic_pkg::ID_W-1:0];
    done_ok  = (wdata >= 32'd1) && (wdata < 32'(pic_pkg::NUM_SOURCES));
  end

  // state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pic_pkg::EN_BITS; i++) begin
        prio_r[i] <= '0;
      end
      for (int c = 0; c < pic_pkg::NUM_CONTEXTS; c++) begin
        enable_r[c] <= '0;
        thresh_r[c] <= '0;
      end
      pend_r  <= '0;
      insvc_r <= '0;
    end else begin
      if (access_en && (mode == pic_pkg::MODE_WRITE)) begin
        if (is_prio && prio_ok) begin
          prio_r[prio_idx] <= wdata[pic_pkg::PRIO_W-1:0];
        end
        if (is_en && en_ok) begin
          for (int w = 0; w < pic_pkg::EN_WORDS; w++) begin
            if ({1'b0, en_w} == 6'(w)) begin
              enable_r[bus_ctx][w*32 +: 32] <= wdata & en_mask;
            end
          end
        end
        if (thr_hit) begin
          thresh_r[bus_ctx] <= wdata[pic_pkg::PRIO_W-1:0];
        end
        if (claim_hit && done_ok) begin
          insvc_r[done_idx] <= 1'b0;
        end
      end
      if (access_en && (mode == pic_pkg::MODE_REQ) && req_ok) begin
        pend_r[src_idx] <= 1'b1;
      end
      // claimed source moves from pending to in service
      if (claim.valid) begin
        pend_r[claim.id]  <= 1'b0;
        insvc_r[claim.id] <= 1'b1;
      end
    end
  end

endmodule

// ----- design/pic_scan.sv -----
// shared priority compare unit, one group of sources per step
`timescale 1ns / 1ps

module pic_scan (
  input  logic                     clk,
  input  logic                     step,
  input  logic                     first,
  input  logic [pic_pkg::GI_W-1:0] grp,
  input  pic_pkg::pic_row_t        row,
  output logic [pic_pkg::ID_W-1:0] best_id
);

  logic [pic_pkg::PRIO_W-1:0] best_prio_r, best_prio_nxt;
  logic [pic_pkg::ID_W-1:0]   best_id_r, best_id_nxt;

  // strict compare in id order keeps ties on the lowest id
  always_comb begin
    best_prio_nxt = first ? row.thresh : best_prio_r;
    best_id_nxt   = first ? '0 : best_id_r;
    for (int k = 0; k < pic_pkg::GROUP; k++) begin
      if (row.qual[k] && (row.prio[k] > best_prio_nxt)) begin
        best_prio_nxt = row.prio[k];
        best_id_nxt   = {grp, pic_pkg::GRP_W'(k)};
      end
    end
  end

  // running best across groups
  always_ff @(posedge clk) begin
    if (step) begin
      best_prio_r <= best_prio_nxt;
      best_id_r   <= best_id_nxt;
    end
  end

  assign best_id = best_id_r;

endmodule

// ----- design/platform_interrupt_controller.sv -----
// top level of the platform interrupt controller: sequencer and result register
// S_ACCESS, then S_SCAN and S_EVAL per notify context, then S_DONE; a claim read
// first scans its own context and claims the winner; a new item is taken only in
// S_IDLE; each search for the best source walks the shared compare unit over 4
// groups of 8 sources; reset: synchronous rst_n clears all priorities, pending,
// in-service, enables and thresholds at once; the block is ready once rst_n is released
`timescale 1ns / 1ps
`include "platform_interrupt_controller_defines.svh"

module platform_interrupt_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [25:0] in_offset,
  input  logic [31:0] in_write_data,
  input  logic [4:0]  in_source_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic [1:0]  out_notify
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ACCESS = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  localparam logic [pic_pkg::GI_W-1:0]  GRP_LAST = pic_pkg::GI_W'(pic_pkg::NUM_GROUPS - 1);
  localparam logic [pic_pkg::CTX_W-1:0] CTX_LAST = pic_pkg::CTX_W'(pic_pkg::NOTE_CTX - 1);

  logic [2:0]                  state_r, state_nxt;
  logic [1:0]                  mode_r, mode_nxt;
  logic [25:0]                 offset_r, offset_nxt;
  logic [31:0]                 wdata_r, wdata_nxt;
  logic [4:0]                  src_r, src_nxt;
  logic [pic_pkg::GI_W-1:0]    grp_r, grp_nxt;
  logic [pic_pkg::CTX_W-1:0]   ctx_r, ctx_nxt;
  logic                        claim_scan_r, claim_scan_nxt;
  logic [31:0]                 rd_r, rd_nxt;
  logic [1:0]                  note_r, note_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [31:0]                 out_rd_r, out_rd_nxt;
  logic [1:0]                  out_note_r, out_note_nxt;

  logic                        access_en;
  logic                        scan_en;
  pic_pkg::pic_claim_t         claim;
  pic_pkg::pic_dec_t           dec;
  pic_pkg::pic_row_t           row;
  logic [31:0]                 bus_rd;
  logic [pic_pkg::ID_W-1:0]    best_id;

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_rd_r;
  assign out_notify    = out_note_r;
  assign access_en     = (state_r == S_ACCESS);
  assign scan_en       = (state_r == S_SCAN);

  pic_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .offset    (offset_r),
    .wdata     (wdata_r),
    .source_id (src_r),
    .access_en (access_en),
    .scan_en   (scan_en),
    .scan_grp  (grp_r),
    .scan_ctx  (ctx_r),
    .claim     (claim),
    .rd_data   (bus_rd),
    .dec       (dec),
    .row       (row)
  );

  pic_scan u_scan (
    .clk     (clk),
    .step    (scan_en),
    .first   (grp_r == '0),
    .grp     (grp_r),
    .row     (row),
    .best_id (best_id)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    offset_nxt     = offset_r;
    wdata_nxt      = wdata_r;
    src_nxt        = src_r;
    grp_nxt        = grp_r;
    ctx_nxt        = ctx_r;
    claim_scan_nxt = claim_scan_r;
    rd_nxt         = rd_r;
    note_nxt       = note_r;
    out_valid_nxt  = out_valid_r;
    out_rd_nxt     = out_rd_r;
    out_note_nxt   = out_note_r;
    claim          = '0;

    // result leaves on an output transfer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_mode;
          offset_nxt = in_offset;
          wdata_nxt  = in_write_data;
          src_nxt    = in_source_id;
          state_nxt  = S_ACCESS;
        end
      end
      // register access; a claim read searches its context first
      S_ACCESS: begin
        rd_nxt   = bus_rd;
        note_nxt = '0;
        grp_nxt  = '0;
        if (dec.claim_rd) begin
          ctx_nxt        = dec.ctx;
          claim_scan_nxt = 1'b1;
        end else begin
          ctx_nxt        = '0;
          claim_scan_nxt = 1'b0;
        end
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (grp_r == GRP_LAST) begin
          grp_nxt   = '0;
          state_nxt = S_EVAL;
        end else begin
          grp_nxt = grp_r + 1'b1;
        end
      end
      S_EVAL: begin
        if (claim_scan_r) begin
          // take the winner, then refresh notify on the updated state
          claim.valid    = (best_id != '0);
          claim.id       = best_id;
          rd_nxt         = 32'(best_id);
          claim_scan_nxt = 1'b0;
          ctx_nxt        = '0;
          state_nxt      = S_SCAN;
        end else begin
          for (int c = 0; c < pic_pkg::NOTE_CTX; c++) begin
            if (ctx_r == pic_pkg::CTX_W'(c)) begin
              note_nxt[c] = (best_id != '0);
            end
          end
          if (ctx_r == CTX_LAST) begin
            state_nxt = S_DONE;
          end else begin
            ctx_nxt   = ctx_r + 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rd_r;
          out_note_nxt  = note_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      grp_r        <= '0;
      ctx_r        <= '0;
      claim_scan_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      grp_r        <= grp_nxt;
      ctx_r        <= ctx_nxt;
      claim_scan_r <= claim_scan_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    offset_r   <= offset_nxt;
    wdata_r    <= wdata_nxt;
    src_r      <= src_nxt;
    rd_r       <= rd_nxt;
    note_r     <= note_nxt;
    out_rd_r   <= out_rd_nxt;
    out_note_r <= out_note_nxt;
  end

  // checks
  `PIC_ASSERT_NEXT(a_transfer_starts_access, in_valid && in_ready, state_r == S_ACCESS)
  `PIC_ASSERT_IMPL(a_eval_after_full_scan, state_r == S_EVAL, $past(state_r) == S_SCAN && $past(grp_r) == GRP_LAST)
  `PIC_ASSERT_IMPL(a_result_from_done, $rose(out_valid_r), $past(state_r) == S_DONE)

endmodule
